// ===== hdl/sgs_pkg.sv =====
// Shared constants for the smoothed gain stage: widths, register indexes, reset values and unity gain.
package sgs_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF     = 24;
  localparam int unsigned GAIN_STATE_WIDTH_DEF = 40;

  // Fixed field widths.
  localparam int unsigned PORT_GAIN_WIDTH = 24;
  localparam int unsigned COEFF_WIDTH     = 24;
  localparam int unsigned THRESH_WIDTH    = 20;
  localparam int unsigned CFG_ADDR_WIDTH  = 3;
  localparam int unsigned CFG_DATA_WIDTH  = 24;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_ENABLE          = 3'd0;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_AUTOMATION_MODE = 3'd1;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_SMOOTH_COEFF    = 3'd2;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_TINY_THRESHOLD  = 3'd3;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_SMALL_THRESHOLD = 3'd4;

  // Register reset values.
  localparam logic                       ENABLE_RST          = 1'b1;
  localparam logic                       AUTOMATION_MODE_RST = 1'b0;
  localparam logic [COEFF_WIDTH-1:0]     SMOOTH_COEFF_RST    = 24'd54815;
  localparam logic [THRESH_WIDTH-1:0]    TINY_THRESHOLD_RST  = 20'd27;
  localparam logic [THRESH_WIDTH-1:0]    SMALL_THRESHOLD_RST = 20'd27488;

  // Unity gain in the Q2.22 port format.
  localparam logic [PORT_GAIN_WIDTH-1:0] UNITY_GAIN = 24'h400000;

endpackage

// ===== hdl/smoothed_gain_stage_unit.sv =====
// Top level of the smoothed gain stage: handshakes, configuration, gain state and output word.
//
// One audio channel streams through this block. Each slave word carries a sample and a
// target gain in tdata, the end-of-block mark in tlast and the resync flag in tuser. Each
// master word carries the gained sample and the gain that was applied in tdata, the
// end-of-block mark in tlast and the clip flag in tuser. Every input word yields exactly
// one output word, in order.
//
// A word accepted into the input register is processed combinationally and moves into
// the output register when that register is free, which raises m_axis_tvalid; the word
// then leaves when the receiver takes it. One word per cycle is sustained while the
// receiver takes every word: the gain update (difference, coefficient multiply, add and
// block-end snap) is combinational and runs in parallel with the sample multiplier.
//
// Reset empties both pipeline registers, sets the gain to zero, marks the next word as a
// block start and loads the registers with their default values. When the receiver
// stalls, the output word holds; the input register still takes one more word, and then
// s_axis_tready drops until the output register drains. Configuration writes take effect
// at once and are meant to happen only while no word is in flight.
module smoothed_gain_stage_unit #(
  parameter int unsigned SAMPLE_WIDTH     = sgs_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned GAIN_STATE_WIDTH = sgs_pkg::GAIN_STATE_WIDTH_DEF,
  localparam int unsigned TDATA_WIDTH     =
    ((SAMPLE_WIDTH + sgs_pkg::PORT_GAIN_WIDTH + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [sgs_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr_i,
  input  logic [sgs_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata_i,
  // Slave stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [TDATA_WIDTH-1:0]              s_axis_tdata,  // sample_in, target_gain, zeros
  input  logic                                s_axis_tlast,  // last_in_block
  input  logic                                s_axis_tuser,  // resync
  // Master stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [TDATA_WIDTH-1:0]              m_axis_tdata,  // sample_out, gain_used, zeros
  output logic                                m_axis_tlast,  // block_end
  output logic                                m_axis_tuser   // clipped
);

  localparam int unsigned SW         = SAMPLE_WIDTH;
  localparam int unsigned GW         = GAIN_STATE_WIDTH;
  localparam int unsigned PGW        = sgs_pkg::PORT_GAIN_WIDTH;
  localparam int unsigned PORT_SHIFT = GW - PGW;

  // Configuration registers.
  logic                              enable_q;
  logic                              automation_q;
  logic [sgs_pkg::COEFF_WIDTH-1:0]   coeff_q;
  logic [sgs_pkg::THRESH_WIDTH-1:0]  tiny_q;
  logic [sgs_pkg::THRESH_WIDTH-1:0]  small_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= sgs_pkg::ENABLE_RST;
      automation_q <= sgs_pkg::AUTOMATION_MODE_RST;
      coeff_q      <= sgs_pkg::SMOOTH_COEFF_RST;
      tiny_q       <= sgs_pkg::TINY_THRESHOLD_RST;
      small_q      <= sgs_pkg::SMALL_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        sgs_pkg::REG_ENABLE:          enable_q     <= cfg_wdata_i[0];
        sgs_pkg::REG_AUTOMATION_MODE: automation_q <= cfg_wdata_i[0];
        sgs_pkg::REG_SMOOTH_COEFF:    coeff_q      <= cfg_wdata_i[sgs_pkg::COEFF_WIDTH-1:0];
        sgs_pkg::REG_TINY_THRESHOLD:  tiny_q       <= cfg_wdata_i[sgs_pkg::THRESH_WIDTH-1:0];
        sgs_pkg::REG_SMALL_THRESHOLD: small_q      <= cfg_wdata_i[sgs_pkg::THRESH_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Handshake control. The input register moves forward whenever the output register is
  // empty or being emptied, so a new word is taken every cycle in steady flow.
  logic in_valid_q;
  logic out_valid_q;
  logic out_free;
  logic advance;
  logic s_accept;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;

  // Input register.
  logic [SW-1:0]  in_sample_q;
  logic [PGW-1:0] in_target_q;
  logic           in_last_q;
  logic           in_resync_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_sample_q <= s_axis_tdata[SW-1:0];
      in_target_q <= s_axis_tdata[SW+PGW-1:SW];
      in_last_q   <= s_axis_tlast;
      in_resync_q <= s_axis_tuser;
    end
  end

  // Gain state.
  logic [GW-1:0] gain_q, gain_d;
  logic          at_start_q;
  logic          simple_q, simple_d;

  logic [GW-1:0] target_ext;
  logic [GW-1:0] gain_cur;
  logic [GW-1:0] gain_stepped;
  logic [GW-1:0] snap_diff;
  logic [GW-1:0] tiny_ext;
  logic [GW-1:0] small_ext;
  logic          simple_now;
  logic [SW-1:0] scaled;
  logic          scaled_clip;

  logic [SW-1:0]  res_sample;
  logic [PGW-1:0] res_gain;
  logic           res_clip;

  assign target_ext = GW'(in_target_q) << PORT_SHIFT;
  assign tiny_ext   = GW'(tiny_q);
  assign small_ext  = GW'(small_q);
  // A resync only counts in automation mode, where it loads the gain before the sample.
  assign gain_cur   = (automation_q && in_resync_q) ? target_ext : gain_q;
  // The simple-block decision is made on the first word of each block.
  assign simple_now = at_start_q ? (gain_q == target_ext) : simple_q;
  assign snap_diff  = (gain_stepped >= target_ext) ? (gain_stepped - target_ext)
                                                   : (target_ext - gain_stepped);

  sgs_scale #(
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .GAIN_STATE_WIDTH (GAIN_STATE_WIDTH)
  ) u_scale (
    .sample_i (in_sample_q),
    .gain_i   (gain_cur),
    .sample_o (scaled),
    .clip_o   (scaled_clip)
  );

  sgs_smooth #(
    .GAIN_STATE_WIDTH (GAIN_STATE_WIDTH)
  ) u_smooth (
    .gain_i   (gain_cur),
    .target_i (target_ext),
    .coeff_i  (coeff_q),
    .gain_o   (gain_stepped)
  );

  always_comb begin
    gain_d     = gain_q;
    simple_d   = simple_q;
    res_sample = in_sample_q;
    res_gain   = sgs_pkg::UNITY_GAIN;
    res_clip   = 1'b0;
    if (enable_q) begin
      res_gain = gain_cur[GW-1:PORT_SHIFT];
      if (automation_q) begin
        simple_d   = 1'b0;
        res_sample = scaled;
        res_clip   = scaled_clip;
        // Automation only snaps a nearly silent gain to zero.
        if (in_last_q && (gain_stepped < tiny_ext)) begin
          gain_d = '0;
        end else begin
          gain_d = gain_stepped;
        end
      end else begin
        simple_d = simple_now;
        if (simple_now) begin
          // Gain is held all block; a very low gain mutes the output.
          if (gain_q < small_ext) begin
            res_sample = '0;
          end else begin
            res_sample = scaled;
            res_clip   = scaled_clip;
          end
        end else begin
          res_sample = scaled;
          res_clip   = scaled_clip;
          gain_d     = gain_stepped;
          if (in_last_q) begin
            if (snap_diff < tiny_ext) begin
              gain_d = target_ext;
            end else if (gain_stepped < tiny_ext) begin
              gain_d = '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= '0;
      at_start_q <= 1'b1;
      simple_q   <= 1'b0;
    end else if (advance) begin
      gain_q     <= gain_d;
      at_start_q <= in_last_q;
      simple_q   <= simple_d;
    end
  end

  // Output register.
  logic [SW-1:0]  out_sample_q;
  logic [PGW-1:0] out_gain_q;
  logic           out_last_q;
  logic           out_clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_sample_q <= res_sample;
      out_gain_q   <= res_gain;
      out_last_q   <= in_last_q;
      out_clip_q   <= res_clip;
    end
  end

  assign m_axis_tdata = TDATA_WIDTH'({out_gain_q, out_sample_q});
  assign m_axis_tlast = out_last_q;
  assign m_axis_tuser = out_clip_q;

endmodule

// ===== hdl/sgs_scale.sv =====
// Sample times gain multiplier with round-half-away rounding and saturation.
module sgs_scale #(
  parameter int unsigned SAMPLE_WIDTH     = sgs_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned GAIN_STATE_WIDTH = sgs_pkg::GAIN_STATE_WIDTH_DEF
) (
  input  logic [SAMPLE_WIDTH-1:0]     sample_i,
  input  logic [GAIN_STATE_WIDTH-1:0] gain_i,
  output logic [SAMPLE_WIDTH-1:0]     sample_o,
  output logic                        clip_o
);

  localparam int unsigned PGW   = sgs_pkg::PORT_GAIN_WIDTH;
  localparam int unsigned GFRAC = GAIN_STATE_WIDTH - 2;
  localparam int unsigned HIW   = GAIN_STATE_WIDTH - PGW;
  localparam int unsigned AW    = SAMPLE_WIDTH + HIW;
  localparam int unsigned BW    = SAMPLE_WIDTH + PGW;
  localparam int unsigned RW    = ((BW > GFRAC) ? BW : GFRAC) + 1;
  localparam int unsigned MW    = ((AW > (RW - PGW)) ? AW : (RW - PGW)) + 1;

  logic                    neg;
  logic [SAMPLE_WIDTH-1:0] mag;
  logic [AW-1:0]           prod_hi;
  logic [BW-1:0]           prod_lo;
  logic [RW-1:0]           rnd_lo;
  logic [MW-1:0]           sum;
  logic [MW-1:0]           scaled;
  logic [MW-1:0]           half;
  logic [MW-1:0]           sat_mag;

  assign neg     = sample_i[SAMPLE_WIDTH-1];
  assign mag     = neg ? (~sample_i + 1'b1) : sample_i;
  // The gain is split at the port boundary so each product stays narrow.
  assign prod_hi = AW'(mag) * AW'(gain_i[GAIN_STATE_WIDTH-1:PGW]);
  assign prod_lo = BW'(mag) * BW'(gain_i[PGW-1:0]);
  assign rnd_lo  = RW'(prod_lo) + (RW'(1) << (GFRAC - 1));
  assign sum     = MW'(prod_hi) + MW'(rnd_lo >> PGW);
  assign scaled  = sum >> (GFRAC - PGW);
  assign half    = MW'(1) << (SAMPLE_WIDTH - 1);

  always_comb begin
    clip_o  = 1'b0;
    sat_mag = scaled;
    if (neg) begin
      if (scaled > half) begin
        sat_mag = half;
        clip_o  = 1'b1;
      end
      sample_o = SAMPLE_WIDTH'(MW'(0) - sat_mag);
    end else begin
      if (scaled > (half - 1'b1)) begin
        sat_mag = half - 1'b1;
        clip_o  = 1'b1;
      end
      sample_o = SAMPLE_WIDTH'(sat_mag);
    end
  end

endmodule

// ===== hdl/sgs_smooth.sv =====
// One-pole low-pass step of the gain toward the target, rounded and never overshooting.
module sgs_smooth #(
  parameter int unsigned GAIN_STATE_WIDTH = sgs_pkg::GAIN_STATE_WIDTH_DEF
) (
  input  logic [GAIN_STATE_WIDTH-1:0]        gain_i,
  input  logic [GAIN_STATE_WIDTH-1:0]        target_i,
  input  logic [sgs_pkg::COEFF_WIDTH-1:0]    coeff_i,
  output logic [GAIN_STATE_WIDTH-1:0]        gain_o
);

  localparam int unsigned GW  = GAIN_STATE_WIDTH;
  localparam int unsigned CW  = sgs_pkg::COEFF_WIDTH;
  localparam int unsigned LW  = 2 * CW + 1;

  logic          up;
  logic [GW-1:0] diff;
  logic [GW-1:0] step_hi;
  logic [LW-1:0] step_lo;
  logic [GW-1:0] step;

  assign up      = target_i >= gain_i;
  assign diff    = up ? (target_i - gain_i) : (gain_i - target_i);
  assign step_hi = GW'(coeff_i) * GW'(diff[GW-1:CW]);
  // Low half of the difference, rounded to the nearest gain LSB with ties up.
  assign step_lo = LW'(coeff_i) * LW'(diff[CW-1:0]) + (LW'(1) << (CW - 1));
  assign step    = step_hi + GW'(step_lo[LW-1:CW]);
  assign gain_o  = up ? (gain_i + step) : (gain_i - step);

endmodule

// ===== hdl/sgs_checker.sv =====
// Port-level checker for the smoothed gain stage, bound to the top level.
module sgs_checker #(
  parameter int unsigned SAMPLE_WIDTH = sgs_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned TDATA_WIDTH  = 48
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [TDATA_WIDTH-1:0] m_axis_tdata,
  input logic                   m_axis_tlast,
  input logic                   m_axis_tuser
);

  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // A stalled output word stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word withdrawn while stalled");

  // A stalled output word keeps its contents.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // The input side only pushes back while the output side is stalled.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  // A clipped sample sits at one of the two saturation limits.
  a_clip_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[SAMPLE_WIDTH-1:0] == SAMPLE_MAX) ||
      (m_axis_tdata[SAMPLE_WIDTH-1:0] == SAMPLE_MIN))
    else $error("clip flag set on an unsaturated sample");

endmodule

bind smoothed_gain_stage_unit sgs_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH),
  .TDATA_WIDTH  (TDATA_WIDTH)
) u_sgs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
